// File: hw/rtl/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// shared constants, controller states and the command/status bundles that
// join the bubble sort controller and datapath
// ----------------------------------------------------------------------------
package bse_pkg;

	localparam int unsigned CAPACITY = 16;                     // elements per set
	localparam int unsigned DW       = 32;                     // element width
	localparam int unsigned AW       = $clog2(CAPACITY);       // store address width
	localparam int unsigned CW       = $clog2(CAPACITY + 1);   // fill count width

	// controller states
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PASS  = 6'b000010,
		S_CARRY = 6'b000100,
		S_CMP   = 6'b001000,
		S_PEND  = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // store or drop the input beat
		logic pass_init;  // reset index, read entry 0
		logic carry_ld;   // take first entry of the pass as the running max
		logic cmp_step;   // compare running max with next entry, write the smaller
		logic pass_end;   // park the running max at the top of the pass
		logic emit;       // read one sorted entry out
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic limit_zero; // no compares left, store is sorted
		logic cmp_last;   // current compare is the last of the pass
		logic emit_last;  // current read is the last element of the set
	} sts_t;

endpackage

// File: hw/rtl/bse_ram.sv
// ----------------------------------------------------------------------------
// bse_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bse_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/bse_ctrl.sv
// ----------------------------------------------------------------------------
// bse_ctrl
// sequencer for load, bubble passes and emit
// ----------------------------------------------------------------------------
module bse_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          final_item,
	input  bse_pkg::sts_t sts,
	output bse_pkg::cmd_t cmd,
	output logic          busy
);

	bse_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bse_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			bse_pkg::S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (final_item) begin
						state_nx = bse_pkg::S_PASS;
					end
				end
			end
			bse_pkg::S_PASS: begin
				cmd.pass_init = 1'b1;
				state_nx = sts.limit_zero ? bse_pkg::S_EMIT : bse_pkg::S_CARRY;
			end
			bse_pkg::S_CARRY: begin
				cmd.carry_ld = 1'b1;
				state_nx = bse_pkg::S_CMP;
			end
			bse_pkg::S_CMP: begin
				cmd.cmp_step = 1'b1;
				if (sts.cmp_last) begin
					state_nx = bse_pkg::S_PEND;
				end
			end
			bse_pkg::S_PEND: begin
				cmd.pass_end = 1'b1;
				state_nx = bse_pkg::S_PASS;
			end
			bse_pkg::S_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.emit_last) begin
					state_nx = bse_pkg::S_IDLE;
				end
			end
			default: begin
				state_nx = bse_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != bse_pkg::S_IDLE);

endmodule

// File: hw/rtl/bse_dp.sv
// ----------------------------------------------------------------------------
// bse_dp
// element store, running max register, counters and result register
// ----------------------------------------------------------------------------
module bse_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bse_pkg::cmd_t                 cmd,
	input  logic signed [bse_pkg::DW-1:0] value,
	output bse_pkg::sts_t                 sts,
	output logic signed [bse_pkg::DW-1:0] sorted_value,
	output logic                          result_valid,
	output logic                          last_result,
	output logic                          dropped
);

	logic [bse_pkg::CW-1:0] count_q;
	logic                   ovf_q;
	logic [bse_pkg::AW-1:0] idx_q;
	logic [bse_pkg::AW-1:0] limit_q;
	logic [bse_pkg::DW-1:0] carry_q;
	logic                   valid_q;
	logic                   last_q;
	logic                   drop_q;

	logic                   room;
	logic                   gt;
	logic                   we;
	logic [bse_pkg::AW-1:0] waddr;
	logic [bse_pkg::DW-1:0] wdata;
	logic [bse_pkg::AW-1:0] raddr;
	logic [bse_pkg::DW-1:0] rdata;

	assign room = (count_q < bse_pkg::CW'(bse_pkg::CAPACITY));
	assign gt   = $signed(carry_q) > $signed(rdata);

	assign sts.limit_zero = (limit_q == '0);
	assign sts.cmp_last   = ((idx_q + bse_pkg::AW'(1)) == limit_q);
	assign sts.emit_last  = ((bse_pkg::CW'(idx_q) + bse_pkg::CW'(1)) == count_q);

	// store port steering
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = carry_q;
		raddr = idx_q;
		if (cmd.load) begin
			we    = room;
			waddr = count_q[bse_pkg::AW-1:0];
			wdata = value;
		end
		if (cmd.pass_init) begin
			raddr = '0;
		end
		if (cmd.carry_ld) begin
			raddr = idx_q + bse_pkg::AW'(1);
		end
		if (cmd.cmp_step) begin
			we    = 1'b1;
			wdata = gt ? rdata : carry_q;
			raddr = idx_q + bse_pkg::AW'(2);
		end
		if (cmd.pass_end) begin
			we    = 1'b1;
			waddr = limit_q;
		end
	end

	bse_ram #(
		.WIDTH(bse_pkg::DW),
		.DEPTH(bse_pkg::CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			idx_q   <= '0;
			limit_q <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
			if (cmd.load) begin
				if (room) begin
					count_q <= count_q + bse_pkg::CW'(1);
					limit_q <= count_q[bse_pkg::AW-1:0];
				end else begin
					ovf_q   <= 1'b1;
					limit_q <= bse_pkg::AW'(bse_pkg::CAPACITY - 1);
				end
			end
			if (cmd.pass_init) begin
				idx_q <= '0;
			end
			if (cmd.cmp_step || cmd.emit) begin
				idx_q <= idx_q + bse_pkg::AW'(1);
			end
			if (cmd.pass_end) begin
				limit_q <= limit_q - bse_pkg::AW'(1);
			end
			if (cmd.emit && sts.emit_last) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.carry_ld || (cmd.cmp_step && !gt)) begin
			carry_q <= rdata;
		end
		if (cmd.emit) begin
			last_q <= sts.emit_last;
			drop_q <= sts.emit_last && ovf_q;
		end
	end

	assign sorted_value = $signed(rdata);
	assign result_valid = valid_q;
	assign last_result  = valid_q && last_q;
	assign dropped      = valid_q && drop_q;

endmodule

// File: hw/rtl/bubble_sort_engine.sv
// ----------------------------------------------------------------------------
// bubble_sort_engine
// streamed ascending sort of up to CAPACITY signed 32-bit values
// ----------------------------------------------------------------------------
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------
//  input    | start & !busy accepts beat  | value, final_item
//  result   | result_valid, one cycle     | sorted_value, last_result, dropped
//
//  - a non-final beat is stored as it is accepted, or dropped once the store
//    is full; busy stays low while loading
//  - the final beat closes the set; the engine stays busy through the bubble
//    passes on the single store read port, then one result per cycle is
//    read out
//  - reset clears the fill count, drop flag and sequencer; store contents
//    are left as they are
//  - results cannot be held off: each one is valid for exactly one cycle
//
module bubble_sort_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	// input beat
	input  logic                          start,
	output logic                          busy,
	input  logic signed [bse_pkg::DW-1:0] value,
	input  logic                          final_item,
	// result beat
	output logic                          result_valid,
	output logic signed [bse_pkg::DW-1:0] sorted_value,
	output logic                          last_result,
	output logic                          dropped
);

	bse_pkg::cmd_t cmd;   // sequencer commands
	bse_pkg::sts_t sts;   // datapath status

	// controller: load, bubble passes with a running max, read out
	bse_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.final_item (final_item),
		.sts        (sts),
		.cmd        (cmd),
		.busy       (busy)
	);

	// datapath: store ram, compare, counters, result register
	bse_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.value        (value),
		.sts          (sts),
		.sorted_value (sorted_value),
		.result_valid (result_valid),
		.last_result  (last_result),
		.dropped      (dropped)
	);

`ifndef SYNTHESIS
	// a final beat always starts a sort
	a_final_starts_sort: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && final_item |=> busy)
		else $error("final beat did not start a sort");

	// drop flag only rides on the last result
	a_drop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && dropped |-> last_result)
		else $error("dropped set on a result other than the last");

	// the engine is free again when the last result goes out
	a_free_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_result |-> !busy)
		else $error("engine still busy on the last result");

	// results only leave while emitting or right after the last read
	a_result_needs_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_result |-> busy)
		else $error("result beat outside of read out");
`endif

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for bubble_sort_engine: sets of signed values are
// streamed in, a local sorting predictor builds the expected result beats,
// and every result beat is compared against the oldest expectation
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CAP        = bse_pkg::CAPACITY;
	localparam int unsigned DW         = bse_pkg::DW;
	localparam int          RANDOM_BEATS = 255;
	localparam int          CYCLE_LIMIT  = 200000;
	localparam int          DRAIN_CYCLES = 64;

	typedef logic signed [DW-1:0] elem_t;

	localparam elem_t ELEM_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam elem_t ELEM_MAX = {1'b0, {(DW-1){1'b1}}};

	// one expected result beat
	typedef struct packed {
		elem_t value;
		logic  last;
		logic  dropped;
	} sorted_beat_t;

	logic  clk          = 1'b0;
	logic  arst_n       = 1'b0;
	logic  start        = 1'b0;
	elem_t value        = '0;
	logic  final_item   = 1'b0;
	logic  busy;
	logic  result_valid;
	elem_t sorted_value;
	logic  last_result;
	logic  dropped;

	// predictor state: the set being collected
	elem_t        set_store[CAP];
	int unsigned  set_fill     = 0;
	logic         set_overflow = 1'b0;
	sorted_beat_t sorted_q[$];

	int mismatch_count = 0;
	int cycle_count    = 0;
	int burst_left     = 0;

	bubble_sort_engine DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.final_item   (final_item),
		.result_valid (result_valid),
		.sorted_value (sorted_value),
		.last_result  (last_result),
		.dropped      (dropped)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// store or drop one element; on the closing element sort the set
	// (strict swap, equal values keep arrival order) and queue the beats
	task automatic take_element(input elem_t v, input logic fin);
		elem_t tmp;
		if (set_fill < CAP) begin
			set_store[set_fill] = v;
			set_fill++;
		end else begin
			set_overflow = 1'b1;
		end
		if (fin) begin
			for (int p = 0; p + 1 < set_fill; p++) begin
				for (int j = 0; j + 1 < set_fill - p; j++) begin
					if (set_store[j] > set_store[j+1]) begin
						tmp            = set_store[j];
						set_store[j]   = set_store[j+1];
						set_store[j+1] = tmp;
					end
				end
			end
			for (int k = 0; k < set_fill; k++) begin
				sorted_q.push_back('{value:   set_store[k],
				                     last:    (k + 1 == set_fill),
				                     dropped: (k + 1 == set_fill) && set_overflow});
			end
			set_fill     = 0;
			set_overflow = 1'b0;
		end
	endtask

	// present one beat and hold it until the engine takes it; called and
	// returns at a rising edge, start stays high for a following beat
	task automatic send_beat(input elem_t v, input logic fin);
		start      <= 1'b1;
		value      <= v;
		final_item <= fin;
		do @(negedge clk); while (busy);
		@(posedge clk);
		take_element(v, fin);
	endtask

	// idle cycles with junk on the payload, which must be ignored
	task automatic idle_cycles(input int n);
		start      <= 1'b0;
		value      <= $urandom;
		final_item <= $urandom_range(0, 1);
		repeat (n) @(posedge clk);
	endtask

	// sender pacing: bursts of random length, random gaps between them,
	// now and then a long burst with no gap at all
	task automatic pace_sender();
		if (burst_left == 0) begin
			idle_cycles($urandom_range(1, 9));
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
			                                         : $urandom_range(1, 10);
		end
		burst_left--;
	endtask

	function automatic elem_t random_element();
		case ($urandom_range(0, 9))
			0: return ELEM_MIN;
			1: return ELEM_MAX;
			2, 3: return elem_t'(int'($urandom_range(0, 6)) - 3); // dense, many ties
			default: return elem_t'($urandom);
		endcase
	endfunction

	// a set of one element, the most negative value
	task automatic test_single_element();
		send_beat(ELEM_MIN, 1'b1);
	endtask

	// field extremes in a small set, closed by the largest value
	task automatic test_extremes();
		send_beat(elem_t'(0), 1'b0);
		send_beat(elem_t'(-1), 1'b0);
		send_beat(ELEM_MIN, 1'b0);
		send_beat(ELEM_MAX, 1'b1);
	endtask

	// full store in descending order with ties, then two more elements;
	// the closing element itself arrives with the store full and is dropped
	task automatic test_overflow();
		for (int i = 0; i < CAP; i++)
			send_beat((i < 2) ? ELEM_MAX : elem_t'((CAP - i) / 2 - 3), 1'b0);
		send_beat(ELEM_MIN, 1'b0);
		send_beat(elem_t'(7), 1'b1);
	endtask

	// random sets, mostly within capacity, some past it, with sender gaps
	task automatic test_random_sets();
		int beats;
		int set_len;
		beats = 0;
		while (beats < RANDOM_BEATS) begin
			case ($urandom_range(0, 9))
				0: set_len = $urandom_range(CAP + 1, CAP + 4);
				1: set_len = CAP;
				2: set_len = 1;
				default: set_len = $urandom_range(2, CAP - 1);
			endcase
			for (int i = 0; i < set_len; i++) begin
				pace_sender();
				send_beat(random_element(), i == set_len - 1);
			end
			beats += set_len;
		end
	endtask

	// result checker: beats are sampled mid-cycle, away from the driving edge
	always @(negedge clk) begin
		sorted_beat_t exp_beat;
		if (arst_n && result_valid) begin
			if (sorted_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result beat: value %0d last %0b dropped %0b",
					         sorted_value, last_result, dropped);
			end else begin
				exp_beat = sorted_q.pop_front();
				if (sorted_value !== exp_beat.value || last_result !== exp_beat.last ||
				    dropped !== exp_beat.dropped) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
						         exp_beat.value, exp_beat.last, exp_beat.dropped,
						         sorted_value, last_result, dropped);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_element();
		test_extremes();
		test_overflow();
		test_random_sets();

		// stop sending, wait for every expected beat, then watch for strays
		start <= 1'b0;
		while (sorted_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && sorted_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
